// ===== sv/fnvh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fnvh_pkg;

  localparam int unsigned MAX_DIGITS = 6;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;
  localparam int unsigned FNV_PRIME_SH = 40;

  function automatic logic [63:0] pow10(input int unsigned n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      acc = acc * 64'd10;
    end
    return acc;
  endfunction

  localparam logic [63:0] CLAMP_LIMIT = pow10(MAX_DIGITS);
  localparam int unsigned VAL_W       = $clog2(CLAMP_LIMIT);
  localparam int unsigned DIG_W       = 4 * MAX_DIGITS;
  localparam int unsigned CNT_W       = $clog2(VAL_W + 1);
  localparam int unsigned IDX_W       = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_INT   = 2'd1,
    OP_EMPTY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_DIGITS,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             byte_step;
    logic             emit_byte;
    logic             emit_basis;
    logic             ld_int;
    logic             dd_step;
    logic             dig_step;
    logic [IDX_W-1:0] dig_idx;
    logic             emit_int;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
  } stat_t;

  // xor the byte in, multiply by the prime (2^40 + 0x1b3) modulo 2^64
  function automatic logic [63:0] fnv_byte(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << FNV_PRIME_SH) + (x * FNV_PRIME_LO);
  endfunction

  // add three to every digit of five or more ahead of the shift
  function automatic logic [DIG_W-1:0] dd_adjust(input logic [DIG_W-1:0] bcd);
    logic [DIG_W-1:0] res;
    res = bcd;
    for (int unsigned i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== sv/fnvh_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface fnvh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  text_byte;
  logic        last_byte;
  logic [63:0] id_value;

  modport source (output valid, output opcode, output text_byte, output last_byte,
                  output id_value, input ready);
  modport sink (input valid, input opcode, input text_byte, input last_byte,
                input id_value, output ready);
endinterface

interface fnvh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_out;

  modport source (output valid, output hash_out, input ready);
  modport sink (input valid, input hash_out, output ready);
endinterface
`default_nettype wire

// ===== sv/fnvh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fnvh_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_opcode,
  input  wire logic             in_last,
  input  wire logic             out_ready,
  input  wire fnvh_pkg::stat_t  stat,
  output logic                  in_ready,
  output fnvh_pkg::cmd_t        cmd
);

  fnvh_pkg::state_t                 state_r, state_nxt;
  logic [fnvh_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [fnvh_pkg::IDX_W-1:0]       dig_r, dig_nxt;
  logic                             out_free;
  logic                             fire;

  assign out_free = !stat.out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fnvh_pkg::ST_IDLE: begin
        if (fire && (fnvh_pkg::op_t'(in_opcode) == fnvh_pkg::OP_INT)) begin
          state_nxt = fnvh_pkg::ST_CONVERT;
        end
      end
      fnvh_pkg::ST_CONVERT: begin
        if (cnt_r == fnvh_pkg::CNT_W'(1)) begin
          state_nxt = fnvh_pkg::ST_DIGITS;
        end
      end
      fnvh_pkg::ST_DIGITS: begin
        if (dig_r == '0) begin
          state_nxt = fnvh_pkg::ST_FINISH;
        end
      end
      fnvh_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = fnvh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fnvh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.dig_idx = dig_r;
    case (state_r)
      fnvh_pkg::ST_IDLE: begin
        in_ready = out_free;
        case (fnvh_pkg::op_t'(in_opcode))
          fnvh_pkg::OP_BYTE: begin
            cmd.byte_step = fire;
            cmd.emit_byte = fire && in_last;
          end
          fnvh_pkg::OP_INT:   cmd.ld_int     = fire;
          fnvh_pkg::OP_EMPTY: cmd.emit_basis = fire;
          default: ;
        endcase
      end
      fnvh_pkg::ST_CONVERT: cmd.dd_step  = 1'b1;
      fnvh_pkg::ST_DIGITS:  cmd.dig_step = 1'b1;
      fnvh_pkg::ST_FINISH:  cmd.emit_int = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    dig_nxt = dig_r;
    if (cmd.ld_int) begin
      cnt_nxt = fnvh_pkg::CNT_W'(fnvh_pkg::VAL_W);
      dig_nxt = fnvh_pkg::IDX_W'(fnvh_pkg::MAX_DIGITS - 1);
    end else begin
      if (cmd.dd_step) begin
        cnt_nxt = cnt_r - fnvh_pkg::CNT_W'(1);
      end
      if (cmd.dig_step && (dig_r != '0)) begin
        dig_nxt = dig_r - fnvh_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fnvh_pkg::ST_IDLE;
      cnt_r   <= '0;
      dig_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dig_r   <= dig_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/fnvh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fnvh_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fnvh_pkg::cmd_t  cmd,
  input  wire logic [7:0]      in_text_byte,
  input  wire logic [63:0]     in_id_value,
  input  wire logic            out_ready,
  output fnvh_pkg::stat_t      stat,
  output logic [63:0]          out_hash
);

  logic [63:0]                  run_r, run_nxt;
  logic [fnvh_pkg::VAL_W-1:0]   bin_r, bin_nxt;
  logic [fnvh_pkg::DIG_W-1:0]   bcd_r, bcd_nxt;
  logic [fnvh_pkg::DIG_W-1:0]   bcd_adj;
  logic [63:0]                  work_r, work_nxt;
  logic                         started_r, started_nxt;
  logic [63:0]                  out_hash_r, out_hash_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [63:0]                  byte_hash;
  logic [3:0]                   digit;
  logic                         take;

  assign byte_hash = fnvh_pkg::fnv_byte(run_r, in_text_byte);
  assign bcd_adj   = fnvh_pkg::dd_adjust(bcd_r);
  assign digit     = bcd_r[cmd.dig_idx*4 +: 4];
  assign take      = started_r || (digit != 4'd0) || (cmd.dig_idx == '0);

  always_comb begin
    run_nxt = run_r;
    if (cmd.byte_step) begin
      run_nxt = cmd.emit_byte ? fnvh_pkg::FNV_BASIS : byte_hash;
    end
  end

  // clamp, then binary to decimal one bit a cycle, then hash from the top digit
  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    work_nxt    = work_r;
    started_nxt = started_r;
    if (cmd.ld_int) begin
      if (in_id_value[63] || (in_id_value >= fnvh_pkg::CLAMP_LIMIT)) begin
        bin_nxt = '0;
      end else begin
        bin_nxt = in_id_value[fnvh_pkg::VAL_W-1:0];
      end
      bcd_nxt     = '0;
      work_nxt    = fnvh_pkg::FNV_BASIS;
      started_nxt = 1'b0;
    end else if (cmd.dd_step) begin
      bcd_nxt = {bcd_adj[fnvh_pkg::DIG_W-2:0], bin_r[fnvh_pkg::VAL_W-1]};
      bin_nxt = bin_r << 1;
    end else if (cmd.dig_step && take) begin
      work_nxt    = fnvh_pkg::fnv_byte(work_r, {4'h3, digit});
      started_nxt = 1'b1;
    end
  end

  always_comb begin
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.emit_byte) begin
      out_hash_nxt  = byte_hash;
      out_valid_nxt = 1'b1;
    end else if (cmd.emit_basis) begin
      out_hash_nxt  = fnvh_pkg::FNV_BASIS;
      out_valid_nxt = 1'b1;
    end else if (cmd.emit_int) begin
      out_hash_nxt  = work_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= fnvh_pkg::FNV_BASIS;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    work_r     <= work_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign stat.out_valid = out_valid_r;
  assign out_hash       = out_hash_r;

endmodule
`default_nettype wire

// ===== sv/fnv1a_feature_hasher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel    dir  payload                                   handshake
// in_chan    in   opcode, text_byte, last_byte, id_value    valid / ready
// out_chan   out  hash_out                                  valid / ready
//
// A string byte folds into the running hash; the last byte of a string, or an empty
// string, puts its hash in the output register. An integer feature is clamped, then
// converted binary to decimal one bit a cycle, then hashed one digit a cycle from the top.
// Reset restores the running string hash to the offset basis and empties the output.
// A request is taken while a result waits only if that result is taken in the same cycle.
module fnv1a_feature_hasher_unit (
  input wire logic     clk,
  input wire logic     rst_n,
  fnvh_in_if.sink      in_chan,
  fnvh_out_if.source   out_chan
);

  fnvh_pkg::cmd_t  cmd;
  fnvh_pkg::stat_t stat;
  logic            in_ready;
  logic [63:0]     hash;

  fnvh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_opcode (in_chan.opcode),
    .in_last   (in_chan.last_byte),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  fnvh_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_text_byte (in_chan.text_byte),
    .in_id_value  (in_chan.id_value),
    .out_ready    (out_chan.ready),
    .stat         (stat),
    .out_hash     (hash)
  );

  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = stat.out_valid;
  assign out_chan.hash_out = hash;

endmodule
`default_nettype wire

// ===== tb/sv/tb_fnv1a_feature_hasher_unit.sv =====
`timescale 1ns / 1ps
module tb_fnv1a_feature_hasher_unit;
  import fnvh_pkg::*;

  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [63:0] HASH_OF_ZERO  = 64'haf63ad4c86019caf;
  localparam logic [63:0] HASH_OF_A     = 64'haf63dc4c8601ec8c;
  localparam logic [63:0] PRIME         = 64'h00000100000001b3;
  localparam int          RANDOM_ITEMS  = 500;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          DRAIN_CYCLES  = 40;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [63:0] id_value;
    bit          pinned;
    logic [63:0] hash;
  } stim_row_t;

  logic clk;
  logic rst_n;

  fnvh_in_if  in_bus();
  fnvh_out_if out_bus();

  fnv1a_feature_hasher_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  logic [63:0] string_hash;
  logic [63:0] expected_hashes[$];
  bit          pin_valid;
  logic [63:0] pin_hash;
  bit          calm;
  int          mismatches;
  int          idle_cycles;
  int          hashes_checked;
  int          op_counts[4];
  stim_row_t   directed[$];

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic logic [63:0] fold_byte(input logic [63:0] h, input logic [7:0] b);
    return (h ^ {56'd0, b}) * PRIME;
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed.insert(directed.size(), row);
  endfunction

  function automatic logic [63:0] hash_decimal(input logic [63:0] id);
    logic [63:0] v;
    logic [63:0] ceiling;
    logic [63:0] h;
    logic [3:0]  digs[20];
    int          n;
    v = id;
    ceiling = 64'd1;
    h = FNV_BASIS;
    n = 0;
    for (int i = 0; i < MAX_DIGITS && i < 19; i++) ceiling = ceiling * 64'd10;
    if (v[63] || v >= ceiling) v = 64'd0;
    do begin
      digs[n] = 4'(v % 64'd10);
      v = v / 64'd10;
      n++;
    end while (v != 64'd0 && n < 20);
    for (int i = n - 1; i >= 0; i--) h = fold_byte(h, 8'h30 + {4'd0, digs[i]});
    return h;
  endfunction

  task automatic advance_hasher(input logic [1:0] opcode, input logic [7:0] text_byte,
                                input logic last_byte, input logic [63:0] id_value,
                                output bit produced, output logic [63:0] hash);
    produced = 1'b0;
    hash = 64'd0;
    case (opcode)
      OP_BYTE: begin
        string_hash = fold_byte(string_hash, text_byte);
        if (last_byte) begin
          produced = 1'b1;
          hash = string_hash;
          string_hash = FNV_BASIS;
        end
      end
      OP_INT: begin
        produced = 1'b1;
        hash = hash_decimal(id_value);
      end
      OP_EMPTY: begin
        produced = 1'b1;
        hash = FNV_BASIS;
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_feature_id();
    logic [63:0] p;
    p = 64'd1;
    case ($urandom_range(0, 6))
      0: return 64'($urandom_range(0, 999999));
      1: return 64'd999990 + 64'($urandom_range(0, 19));
      2: return {$urandom, $urandom};
      3: return -64'($urandom_range(1, 1000));
      4: return {1'b1, 31'($urandom), $urandom};
      5: begin
        repeat ($urandom_range(0, 7)) p = p * 64'd10;
        return p - 64'($urandom_range(0, 1));
      end
      default: return 64'($urandom_range(0, 99));
    endcase
  endfunction

  task automatic send_request(input logic [1:0] opcode, input logic [7:0] text_byte,
                              input logic last_byte, input logic [63:0] id_value,
                              input bit pinned, input logic [63:0] hash);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.opcode    <= opcode;
    in_bus.text_byte <= text_byte;
    in_bus.last_byte <= last_byte;
    in_bus.id_value  <= id_value;
    pin_valid = pinned;
    pin_hash  = hash;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic send_plain(input logic [1:0] opcode, input logic [7:0] text_byte,
                            input logic last_byte, input logic [63:0] id_value);
    send_request(opcode, text_byte, last_byte, id_value, 1'b0, 64'd0);
  endtask

  task automatic send_interjection();
    case ($urandom_range(0, 3))
      0, 1: send_plain(OP_INT, 8'($urandom), 1'($urandom), pick_feature_id());
      2: send_plain(OP_EMPTY, 8'($urandom), 1'($urandom), {$urandom, $urandom});
      default: send_plain(OP_UNUSED, 8'($urandom), 1'($urandom), {$urandom, $urandom});
    endcase
  endtask

  always @(posedge clk) begin : monitor
    bit          produced;
    logic [63:0] hash;
    logic [63:0] want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        advance_hasher(in_bus.opcode, in_bus.text_byte, in_bus.last_byte, in_bus.id_value,
                       produced, hash);
        if (produced) begin
          expected_hashes.insert(expected_hashes.size(), pin_valid ? pin_hash : hash);
        end
        op_counts[in_bus.opcode]++;
      end
      if (out_bus.valid && out_bus.ready) begin
        hashes_checked++;
        if (expected_hashes.size() == 0) begin
          $error("hash_out: unexpected result %h", out_bus.hash_out);
          mismatches++;
        end else begin
          want = expected_hashes.pop_front();
          if (out_bus.hash_out !== want) begin
            $error("hash_out mismatch: expected %h, actual %h", want, out_bus.hash_out);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[fnv1a_feature_hasher_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sink_pacing
    int hold;
    int r;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_bus.ready <= 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_bus.ready <= 1'b1;
          hold = $urandom_range(0, 4);
        end else if (r < 92) begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(0, 2);
        end else begin
          out_bus.ready <= 1'b0;
          hold = $urandom_range(10, 40);
        end
      end
    end
  end

  initial begin : stimulus
    int sent;
    int len;
    in_bus.valid     = 1'b0;
    in_bus.opcode    = OP_BYTE;
    in_bus.text_byte = 8'd0;
    in_bus.last_byte = 1'b0;
    in_bus.id_value  = 64'd0;
    pin_valid        = 1'b0;
    pin_hash         = 64'd0;
    calm             = 1'b0;
    mismatches       = 0;
    idle_cycles      = 0;
    hashes_checked   = 0;
    string_hash      = FNV_BASIS;
    foreach (op_counts[i]) op_counts[i] = 0;
    rst_n = 1'b0;

    add_row('{OP_EMPTY, 8'h00, 1'b0, 64'd0, 1'b1, FNV_BASIS});
    add_row('{OP_INT, 8'h00, 1'b0, 64'd0, 1'b1, HASH_OF_ZERO});
    add_row('{OP_INT, 8'h00, 1'b0, 64'hffffffffffffffff, 1'b1, HASH_OF_ZERO});
    add_row('{OP_INT, 8'h00, 1'b0, 64'h8000000000000000, 1'b1, HASH_OF_ZERO});
    add_row('{OP_INT, 8'h00, 1'b0, 64'h7fffffffffffffff, 1'b1, HASH_OF_ZERO});
    add_row('{OP_INT, 8'h00, 1'b0, 64'd1000000, 1'b1, HASH_OF_ZERO});
    add_row('{OP_INT, 8'h00, 1'b0, 64'd999999, 1'b0, 64'd0});
    add_row('{OP_INT, 8'h00, 1'b0, 64'd1, 1'b0, 64'd0});
    add_row('{OP_INT, 8'h00, 1'b0, 64'd10, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'h61, 1'b1, 64'd0, 1'b1, HASH_OF_A});
    add_row('{OP_BYTE, 8'h00, 1'b1, 64'd0, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'hff, 1'b0, 64'd0, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'h00, 1'b0, 64'd0, 1'b0, 64'd0});
    add_row('{OP_INT, 8'hff, 1'b1, 64'd123456, 1'b0, 64'd0});
    add_row('{OP_EMPTY, 8'hff, 1'b1, 64'hffffffffffffffff, 1'b1, FNV_BASIS});
    add_row('{OP_UNUSED, 8'hff, 1'b1, 64'hffffffffffffffff, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'h80, 1'b1, 64'hffffffffffffffff, 1'b0, 64'd0});
    add_row('{OP_EMPTY, 8'hff, 1'b1, 64'h7fffffffffffffff, 1'b1, FNV_BASIS});
    add_row('{OP_INT, 8'hff, 1'b1, 64'd100000, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'h7f, 1'b0, 64'd0, 1'b0, 64'd0});
    add_row('{OP_UNUSED, 8'h00, 1'b0, 64'd0, 1'b0, 64'd0});
    add_row('{OP_BYTE, 8'h55, 1'b1, 64'd0, 1'b0, 64'd0});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_request(directed[i].opcode, directed[i].text_byte, directed[i].last_byte,
                   directed[i].id_value, directed[i].pinned, directed[i].hash);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_interjection();
              sent++;
            end
            send_plain(OP_BYTE, 8'($urandom), k == len - 1, {$urandom, $urandom});
            sent++;
          end
        end
        6, 7: begin
          send_plain(OP_INT, 8'($urandom), 1'($urandom), pick_feature_id());
          sent++;
        end
        8: begin
          send_plain(OP_EMPTY, 8'($urandom), 1'($urandom), {$urandom, $urandom});
          sent++;
        end
        default: send_plain(OP_UNUSED, 8'($urandom), 1'($urandom), {$urandom, $urandom});
      endcase
    end
    calm = 1'b0;

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Requests: %0d string bytes, %0d integer features, %0d empty strings, %0d ignored",
             op_counts[OP_BYTE], op_counts[OP_INT], op_counts[OP_EMPTY], op_counts[OP_UNUSED]);
    $display("Hashes compared: %0d, mismatches: %0d", hashes_checked, mismatches);
    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("[fnv1a_feature_hasher_unit] OK");
    end else begin
      $display("[fnv1a_feature_hasher_unit] ERROR");
    end
    $finish;
  end

endmodule
